FILE: hdl/assert_macros.svh
// Assertion macros used by the mailbox datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MBX_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mailbox assertion failed");
`define MBX_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define MBX_ASSERT(label, prop)
`define MBX_ASSERT_MSG(label, prop, msg)
`endif
`endif

FILE: hdl/i2cmbx_pkg.sv
// Types and constants of the I2C target message mailbox.
package i2cmbx_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_BUS     = 2'd0;
  localparam logic [1:0] CMD_TX_BYTE = 2'd1;
  localparam logic [1:0] CMD_RX_READ = 2'd2;

  // Bus status codes that come with a bus event.
  localparam logic [2:0] BS_ADDR_W  = 3'd0;
  localparam logic [2:0] BS_DATA_RX = 3'd1;
  localparam logic [2:0] BS_ADDR_R  = 3'd2;
  localparam logic [2:0] BS_TX_ACK  = 3'd3;
  localparam logic [2:0] BS_TX_NACK = 3'd4;

  // Byte loaded when an address+read finds a queued message.
  localparam logic [7:0] POP_MARK = 8'h80;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] bus_status;
    logic [7:0] rx_byte;
    logic [7:0] msg_byte;
    logic [3:0] byte_index;
    logic       msg_last;
    logic [3:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_loaded;
    logic [7:0] read_byte;
    logic [3:0] rx_newest;
    logic [3:0] rx_oldest;
    logic       tx_queue_empty;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DATA_RX,
    OP_ADDR_R,
    OP_TX_ACK,
    OP_TX_NACK,
    OP_LOCAL_WR,
    OP_LOCAL_RD
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RX_COPY,
    ST_TX_COPY,
    ST_TX_LOAD,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic rx_store;
    logic rx_commit;
    logic rx_copy;
    logic rx_copy_done;
    logic tx_pop;
    logic tx_empty_load;
    logic tx_copy;
    logic copy_reset;
    logic copy_step;
    logic tx_load_take;
    logic tx_count_clear;
    logic local_write;
    logic local_read_take;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic rx_zero;
    logic rx_full;
    logic tx_empty;
    logic copy_end;
    logic clr_end;
    logic out_free;
  } ctrl_stat_t;

endpackage

FILE: hdl/i2cmbx_ram.sv
// Generic single write port, single read port RAM with registered read.
module i2cmbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/i2cmbx_ctrl.sv
// Controller state machine of the mailbox: sequences each input word.
module i2cmbx_ctrl import i2cmbx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_FINISH;
        case (stat.op)
          OP_DATA_RX: begin
            if (stat.rx_zero) begin
              cmd.rx_commit  = 1'b1;
              cmd.copy_reset = 1'b1;
              state_next     = ST_RX_COPY;
            end else if (!stat.rx_full) begin
              cmd.rx_store = 1'b1;
            end
          end
          OP_ADDR_R: begin
            if (stat.tx_empty) begin
              cmd.tx_empty_load = 1'b1;
            end else begin
              cmd.tx_pop     = 1'b1;
              cmd.copy_reset = 1'b1;
              state_next     = ST_TX_COPY;
            end
          end
          OP_TX_ACK, OP_TX_NACK: begin
            state_next = ST_TX_LOAD;
          end
          OP_LOCAL_WR: begin
            cmd.local_write = 1'b1;
          end
          OP_LOCAL_RD: begin
            state_next = ST_RD_WAIT;
          end
          default: begin
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_RX_COPY: begin
        cmd.rx_copy = 1'b1;
        if (stat.copy_end) begin
          cmd.rx_copy_done = 1'b1;
          state_next       = ST_FINISH;
        end else begin
          cmd.copy_step = 1'b1;
        end
      end
      ST_TX_COPY: begin
        cmd.tx_copy = 1'b1;
        if (stat.copy_end) begin
          state_next = ST_FINISH;
        end else begin
          cmd.copy_step = 1'b1;
        end
      end
      ST_TX_LOAD: begin
        cmd.tx_load_take   = 1'b1;
        cmd.tx_count_clear = (stat.op == OP_TX_NACK);
        state_next         = ST_FINISH;
      end
      ST_RD_WAIT: begin
        cmd.local_read_take = 1'b1;
        state_next          = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/i2cmbx_dp.sv
// Datapath of the mailbox: rings, assembly buffers, pointers and the result register.
`include "assert_macros.svh"
module i2cmbx_dp import i2cmbx_pkg::*; #(
  parameter int MSG_BYTES  = 16,
  parameter int RING_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   item,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  output out_item_t  result,
  output logic       result_valid,
  input  logic       result_stall
);

  localparam int BW        = $clog2(MSG_BYTES);
  localparam int CW        = $clog2(MSG_BYTES + 1);
  localparam int SW        = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = RING_DEPTH * MSG_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    logic [SW-1:0] n;
    n = (s == SW'(RING_DEPTH - 1)) ? '0 : s + SW'(1);
    return n;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] slot,
                                               input logic [BW-1:0] b);
    logic [AW-1:0] a;
    a = AW'(slot) * AW'(MSG_BYTES) + AW'(b);
    return a;
  endfunction

  in_item_t      item_q;
  logic [CW-1:0] rx_count;
  logic [CW-1:0] tx_count;
  logic [SW-1:0] rx_head;
  logic [SW-1:0] rx_tail;
  logic [SW-1:0] tx_head;
  logic [SW-1:0] tx_tail;
  logic [SW-1:0] copy_slot;
  logic [CW-1:0] copy_idx;
  logic [AW-1:0] clr_addr;
  logic          cur_zero;
  logic [7:0]    res_tx_byte;
  logic          res_tx_loaded;
  logic [7:0]    res_read_byte;

  logic [SW-1:0] commit_slot;
  logic [CW-1:0] copy_prev;
  logic [BW-1:0] copy_wr_byte;
  logic [BW-1:0] copy_rd_byte;
  logic [BW+3:0] byte_ext;
  logic [SW+3:0] entry_ext;
  logic [BW-1:0] bsel;
  logic [SW-1:0] eslot;
  logic          bidx_ok;
  logic          eidx_ok;
  logic          tx_more;
  logic          copy_wr;
  logic [SW+3:0] tail_ext;
  logic [SW+3:0] head_ext;
  op_t           op;

  logic          rxr_we;
  logic [AW-1:0] rxr_waddr;
  logic [7:0]    rxr_wdata;
  logic [7:0]    rxr_rdata;
  logic          txr_we;
  logic [AW-1:0] txr_waddr;
  logic [7:0]    txr_wdata;
  logic [7:0]    txr_rdata;
  logic [7:0]    asm_rdata;
  logic [7:0]    cur_rdata;

  assign commit_slot  = next_slot(rx_tail);
  assign copy_prev    = copy_idx - CW'(1);
  assign copy_wr_byte = copy_prev[BW-1:0];
  assign copy_rd_byte = copy_idx[BW-1:0];
  assign byte_ext     = {{BW{1'b0}}, item_q.byte_index};
  assign entry_ext    = {{SW{1'b0}}, item_q.entry_index};
  assign bsel         = byte_ext[BW-1:0];
  assign eslot        = entry_ext[SW-1:0];
  assign bidx_ok      = (32'(item_q.byte_index) < MSG_BYTES);
  assign eidx_ok      = (32'(item_q.entry_index) < RING_DEPTH);
  assign tx_more      = (tx_count < CW'(MSG_BYTES));
  assign copy_wr      = (copy_idx != '0);
  assign tail_ext     = {4'b0000, rx_tail};
  assign head_ext     = {4'b0000, rx_head};

  always_comb begin
    op = OP_NONE;
    case (item_q.cmd)
      CMD_BUS: begin
        case (item_q.bus_status)
          BS_DATA_RX: op = OP_DATA_RX;
          BS_ADDR_R:  op = OP_ADDR_R;
          BS_TX_ACK:  op = OP_TX_ACK;
          BS_TX_NACK: op = OP_TX_NACK;
          default:    op = OP_NONE;
        endcase
      end
      CMD_TX_BYTE: op = OP_LOCAL_WR;
      CMD_RX_READ: op = OP_LOCAL_RD;
      default:     op = OP_NONE;
    endcase
  end

  assign stat.op       = op;
  assign stat.rx_zero  = (item_q.rx_byte == 8'h00);
  assign stat.rx_full  = (rx_count == CW'(MSG_BYTES));
  assign stat.tx_empty = (tx_head == tx_tail);
  assign stat.copy_end = (copy_idx == CW'(MSG_BYTES));
  assign stat.clr_end  = (clr_addr == AW'(MEM_DEPTH - 1));
  assign stat.out_free = !result_valid || !result_stall;

  // Receive ring: cleared after reset, filled by commit copies, read locally.
  assign rxr_we    = cmd.clr_step || (cmd.rx_copy && copy_wr);
  assign rxr_waddr = cmd.clr_step ? clr_addr : slot_addr(copy_slot, copy_wr_byte);
  assign rxr_wdata = (!cmd.clr_step && (copy_prev < rx_count)) ? asm_rdata : 8'h00;

  i2cmbx_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_rx_ring (
    .clk   (clk),
    .we    (rxr_we),
    .waddr (rxr_waddr),
    .wdata (rxr_wdata),
    .raddr (slot_addr(eslot, bsel)),
    .rdata (rxr_rdata)
  );

  // Transmit ring: cleared after reset, written locally, read by pop copies.
  assign txr_we    = cmd.clr_step || (cmd.local_write && bidx_ok);
  assign txr_waddr = cmd.clr_step ? clr_addr : slot_addr(tx_tail, bsel);
  assign txr_wdata = cmd.clr_step ? 8'h00 : item_q.msg_byte;

  i2cmbx_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_tx_ring (
    .clk   (clk),
    .we    (txr_we),
    .waddr (txr_waddr),
    .wdata (txr_wdata),
    .raddr (slot_addr(copy_slot, copy_rd_byte)),
    .rdata (txr_rdata)
  );

  // Bytes past rx_count read as zero during a commit, so no clearing is needed.
  i2cmbx_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_rx_assembly (
    .clk   (clk),
    .we    (cmd.rx_store),
    .waddr (rx_count[BW-1:0]),
    .wdata (item_q.rx_byte),
    .raddr (copy_rd_byte),
    .rdata (asm_rdata)
  );

  // cur_zero stands for an all-zero current message.
  i2cmbx_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_tx_current (
    .clk   (clk),
    .we    (cmd.tx_copy && copy_wr),
    .waddr (copy_wr_byte),
    .wdata (txr_rdata),
    .raddr (tx_count[BW-1:0]),
    .rdata (cur_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count     <= '0;
      tx_count     <= '0;
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      copy_idx     <= '0;
      clr_addr     <= '0;
      cur_zero     <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.rx_store) begin
        rx_count <= rx_count + CW'(1);
      end
      if (cmd.rx_commit) begin
        rx_tail <= commit_slot;
        if (commit_slot == rx_head) begin
          rx_head <= next_slot(rx_head);
        end
      end
      if (cmd.rx_copy_done) begin
        rx_count <= '0;
      end
      if (cmd.tx_pop) begin
        tx_head  <= next_slot(tx_head);
        cur_zero <= 1'b0;
      end
      if (cmd.tx_empty_load) begin
        cur_zero <= 1'b1;
      end
      if (cmd.copy_reset) begin
        copy_idx <= '0;
      end else if (cmd.copy_step) begin
        copy_idx <= copy_idx + CW'(1);
      end
      if (cmd.tx_load_take) begin
        if (cmd.tx_count_clear) begin
          tx_count <= '0;
        end else if (tx_more) begin
          tx_count <= tx_count + CW'(1);
        end
      end
      if (cmd.local_write && item_q.msg_last) begin
        tx_tail <= next_slot(tx_tail);
      end
      if (cmd.push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q        <= item;
      res_tx_byte   <= 8'h00;
      res_tx_loaded <= 1'b0;
      res_read_byte <= 8'h00;
    end
    if (cmd.rx_commit) begin
      copy_slot <= commit_slot;
    end
    if (cmd.tx_pop) begin
      copy_slot     <= tx_head;
      res_tx_byte   <= POP_MARK;
      res_tx_loaded <= 1'b1;
    end
    if (cmd.tx_empty_load) begin
      res_tx_byte   <= 8'h00;
      res_tx_loaded <= 1'b1;
    end
    if (cmd.tx_load_take) begin
      res_tx_byte   <= (tx_more && !cur_zero) ? cur_rdata : 8'h00;
      res_tx_loaded <= 1'b1;
    end
    if (cmd.local_read_take) begin
      res_read_byte <= (eidx_ok && bidx_ok) ? rxr_rdata : 8'h00;
    end
    if (cmd.push) begin
      result.tx_byte        <= res_tx_byte;
      result.tx_loaded      <= res_tx_loaded;
      result.read_byte      <= res_read_byte;
      result.rx_newest      <= tail_ext[3:0];
      result.rx_oldest      <= head_ext[3:0];
      result.tx_queue_empty <= (tx_head == tx_tail);
    end
  end

  `MBX_ASSERT(a_commit_keeps_entry, cmd.rx_commit |=> (rx_tail != rx_head))
  `MBX_ASSERT(a_rx_count_bounded, rx_count <= CW'(MSG_BYTES))
  `MBX_ASSERT(a_tx_count_bounded, tx_count <= CW'(MSG_BYTES))
  `MBX_ASSERT(a_copy_idx_bounded, copy_idx <= CW'(MSG_BYTES))
  `MBX_ASSERT_MSG(a_word_from_push, $rose(result_valid) |-> $past(cmd.push), "result word without push")

endmodule

FILE: hdl/i2c_target_message_mailbox.sv
// Each word passes through the decode and finish states; a transmit load or local read adds its
// load or read state between them, and a commit or pop adds the message copy through RAM ports,
// one byte per cycle.
// One word at a time: the next word is accepted only after the result word has been pushed.
// Reset: synchronous; afterwards all RING_DEPTH * MSG_BYTES addresses of both rings (256 by
// default) are zeroed while item_stall stays high.
module i2c_target_message_mailbox import i2cmbx_pkg::*; #(
  parameter int MSG_BYTES  = 16,
  parameter int RING_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  // The controller decodes each accepted word and steps the datapath
  // through its copy, load or read sequence, then hands the result word
  // to the output register. A waiting result word does not block the
  // next input word from being accepted.

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  i2cmbx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath owns the receive and transmit rings, the receive
  // assembly buffer, the current transmit message and all pointers.
  i2cmbx_dp #(
    .MSG_BYTES  (MSG_BYTES),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

FILE: tb/tb_i2c_target_message_mailbox.sv
// Self-checking testbench for the I2C target message mailbox: directed table, corner runs, then random traffic.
module tb_i2c_target_message_mailbox;
  import i2cmbx_pkg::*;

  localparam int MSG_BYTES  = 16;
  localparam int RING_DEPTH = 16;

  // Codes that the package leaves unnamed: the idle command and the bus states with no action.
  localparam logic [1:0] CMD_NOP     = 2'd3;
  localparam logic [2:0] BS_OTHER_LO = 3'd5;
  localparam logic [2:0] BS_OTHER_HI = 3'd7;

  // Random traffic stops after this many effective words; the last QUIET_WORDS run without idling.
  localparam int RANDOM_WORDS = 450;
  localparam int QUIET_WORDS  = 80;
  // A commit or pop copies MSG_BYTES bytes, so this covers any word still in flight.
  localparam int SETTLE_CYCLES = 2 * MSG_BYTES + 10;
  // The clearing pass after reset zeroes RING_DEPTH * MSG_BYTES addresses; everything else is far shorter.
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  i2c_target_message_mailbox #(
    .MSG_BYTES (MSG_BYTES),
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------------
  // Mailbox model. It mirrors the block's state: both message rings, the receive assembly buffer,
  // the message being sent on the bus, and the ring pointers. Everything starts at zero, which is
  // also the state the block reaches after its clearing pass.
  // ---------------------------------------------------------------------------------------------
  bit [MSG_BYTES-1:0][7:0] rx_msgs [RING_DEPTH];
  bit [MSG_BYTES-1:0][7:0] tx_msgs [RING_DEPTH];
  bit [MSG_BYTES-1:0][7:0] rx_partial;
  bit [MSG_BYTES-1:0][7:0] tx_sending;
  int rx_fill;
  int tx_sent;
  int rx_oldest_slot;
  int rx_newest_slot;
  int tx_pop_slot;
  int tx_push_slot;
  int rx_commits;
  int tx_pops;

  function automatic int ring_next(int slot);
    return (slot + 1 >= RING_DEPTH) ? 0 : slot + 1;
  endfunction

  // Next byte of the message on the bus; zeros once the whole message has gone.
  function automatic logic [7:0] tx_next_byte();
    logic [7:0] b;
    if (tx_sent >= MSG_BYTES) return 8'h00;
    b = tx_sending[tx_sent];
    tx_sent++;
    return b;
  endfunction

  function automatic out_item_t mailbox_outcome(in_item_t w);
    out_item_t r;
    r = '0;
    case (w.cmd)
      CMD_BUS: begin
        case (w.bus_status)
          BS_DATA_RX: begin
            // Bytes past a full message are dropped, but a zero byte always commits.
            if (rx_fill < MSG_BYTES) begin
              rx_partial[rx_fill] = w.rx_byte;
              rx_fill++;
            end
            if (w.rx_byte == 8'h00) begin
              rx_newest_slot = ring_next(rx_newest_slot);
              // A full ring loses its oldest message.
              if (rx_newest_slot == rx_oldest_slot) rx_oldest_slot = ring_next(rx_oldest_slot);
              rx_msgs[rx_newest_slot] = rx_partial;
              rx_partial = '0;
              rx_fill = 0;
              rx_commits++;
            end
          end
          BS_ADDR_R: begin
            // The byte counter is left alone here; only a nack rewinds it.
            if (tx_pop_slot == tx_push_slot) begin
              tx_sending = '0;
              r.tx_byte = 8'h00;
            end else begin
              tx_sending = tx_msgs[tx_pop_slot];
              r.tx_byte = POP_MARK;
              tx_pop_slot = ring_next(tx_pop_slot);
              tx_pops++;
            end
            r.tx_loaded = 1'b1;
          end
          BS_TX_ACK: begin
            r.tx_byte = tx_next_byte();
            r.tx_loaded = 1'b1;
          end
          BS_TX_NACK: begin
            r.tx_byte = tx_next_byte();
            tx_sent = 0;
            r.tx_loaded = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_TX_BYTE: begin
        // No full check: enough closed messages make the queue wrap onto itself and read as empty.
        if (int'(w.byte_index) < MSG_BYTES) tx_msgs[tx_push_slot][w.byte_index] = w.msg_byte;
        if (w.msg_last) tx_push_slot = ring_next(tx_push_slot);
      end
      CMD_RX_READ: begin
        if (int'(w.entry_index) < RING_DEPTH && int'(w.byte_index) < MSG_BYTES)
          r.read_byte = rx_msgs[w.entry_index][w.byte_index];
      end
      default: ;
    endcase
    r.rx_newest = 4'(rx_newest_slot);
    r.rx_oldest = 4'(rx_oldest_slot);
    r.tx_queue_empty = (tx_pop_slot == tx_push_slot);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Result checking. Every accepted word leaves one entry here; each accepted result must match
  // the oldest entry field by field.
  // ---------------------------------------------------------------------------------------------
  out_item_t pending_results[$];
  int        mismatches;
  int        results_checked;

  function automatic string show_result(out_item_t r);
    return $sformatf("tx_byte=%h tx_loaded=%b read_byte=%h rx_newest=%h rx_oldest=%h empty=%b",
                     r.tx_byte, r.tx_loaded, r.read_byte, r.rx_newest, r.rx_oldest,
                     r.tx_queue_empty);
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Result with no word outstanding: %s", show_result(got));
    end else begin
      want = pending_results.pop_front();
      if (got.tx_byte !== want.tx_byte || got.tx_loaded !== want.tx_loaded ||
          got.read_byte !== want.read_byte || got.rx_newest !== want.rx_newest ||
          got.rx_oldest !== want.rx_oldest || got.tx_queue_empty !== want.tx_queue_empty) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Result %0d differs", results_checked);
          $display("  expected %s", show_result(want));
          $display("  actual   %s", show_result(got));
        end
      end
    end
  endtask

  // Idling control. idle_mode is re-rolled per random sequence so that stretches without any
  // idling occur; quiet turns idling off for the tail of the run.
  bit idle_mode = 1'b1;
  bit quiet = 1'b0;
  int stall_left;

  // Result side: take results and stall in random bursts.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result(result);
    if (stall_left != 0)
      stall_left--;
    else if (idle_mode && !quiet && $urandom_range(0, 6) == 0)
      stall_left = $urandom_range(1, 11);
    result_stall <= (stall_left != 0);
  end

  // Watchdog: the run is stuck if neither side moves a word for too long.
  int quiet_cycles;
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Stimulus side.
  // ---------------------------------------------------------------------------------------------
  int words_posted;

  // Fields a command does not use are still random, so every input bit toggles.
  function automatic in_item_t random_word();
    logic [31:0] raw;
    raw = $urandom;
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t bus_word(logic [2:0] status, logic [7:0] rxb);
    in_item_t w;
    w = random_word();
    w.cmd = CMD_BUS;
    w.bus_status = status;
    w.rx_byte = rxb;
    return w;
  endfunction

  function automatic in_item_t tx_word(logic [3:0] idx, logic [7:0] b, logic last);
    in_item_t w;
    w = random_word();
    w.cmd = CMD_TX_BYTE;
    w.byte_index = idx;
    w.msg_byte = b;
    w.msg_last = last;
    return w;
  endfunction

  function automatic in_item_t read_word(logic [3:0] entry, logic [3:0] idx);
    in_item_t w;
    w = random_word();
    w.cmd = CMD_RX_READ;
    w.entry_index = entry;
    w.byte_index = idx;
    return w;
  endfunction

  // Words that change state or return data; ignored bus states and the idle command do not count.
  function automatic bit is_effective(in_item_t w);
    if (w.cmd == CMD_TX_BYTE || w.cmd == CMD_RX_READ) return 1'b1;
    return w.cmd == CMD_BUS && (w.bus_status == BS_DATA_RX || w.bus_status == BS_ADDR_R ||
                                w.bus_status == BS_TX_ACK || w.bus_status == BS_TX_NACK);
  endfunction

  // Present one word, hold it until the block takes it, and record what it should produce.
  // A typed-in expectation replaces the model's, but the model still tracks the state.
  task automatic post_word(input in_item_t w, input bit typed, input out_item_t want);
    out_item_t modeled;
    if (idle_mode && !quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    modeled = mailbox_outcome(w);
    pending_results.push_back(typed ? want : modeled);
    if (is_effective(w)) words_posted++;
  endtask

  task automatic post(input in_item_t w);
    post_word(w, 1'b0, '0);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic out_item_t outcome_of(logic [7:0] txb, logic loaded, logic [7:0] rdb,
                                           logic [3:0] newest, logic [3:0] oldest, logic empty);
    out_item_t r;
    r.tx_byte = txb;
    r.tx_loaded = loaded;
    r.read_byte = rdb;
    r.rx_newest = newest;
    r.rx_oldest = oldest;
    r.tx_queue_empty = empty;
    return r;
  endfunction

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t want;
  } script_row_t;

  script_row_t script[$];

  function automatic void add_row(in_item_t w, bit typed, out_item_t want);
    script_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    script.push_back(row);
  endfunction

  // Random sequences. Most are well formed with random content; a few are cut short or noise.
  task automatic run_rx_message();
    int len;
    if ($urandom_range(0, 1) == 0) post(bus_word(BS_ADDR_W, 8'($urandom)));
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(MSG_BYTES, MSG_BYTES + 4)
                                      : $urandom_range(0, MSG_BYTES - 1);
    repeat (len) post(bus_word(BS_DATA_RX, 8'($urandom_range(1, 255))));
    if ($urandom_range(0, 9) != 0) post(bus_word(BS_DATA_RX, 8'h00));
  endtask

  task automatic run_tx_message();
    int len;
    bit scatter;
    len = $urandom_range(1, MSG_BYTES);
    scatter = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++)
      post(tx_word(scatter ? 4'($urandom) : 4'(i), 8'($urandom),
                   i == len - 1 && $urandom_range(0, 9) != 0));
  endtask

  task automatic run_bus_read();
    post(bus_word(BS_ADDR_R, 8'($urandom)));
    repeat ($urandom_range(0, MSG_BYTES + 2)) post(bus_word(BS_TX_ACK, 8'($urandom)));
    if ($urandom_range(0, 4) != 0) post(bus_word(BS_TX_NACK, 8'($urandom)));
  endtask

  initial begin : stimulus
    int kind;
    int directed_words;
    bit paused;

    // Directed table. Rows with a typed-in result start from the all-zero state or follow it
    // closely enough to read off by hand; the rest go through the model.
    add_row(bus_word(BS_ADDR_R, 8'h00), 1'b1, outcome_of(8'h00, 1'b1, 8'h00, 4'd0, 4'd0, 1'b1));
    add_row(bus_word(BS_TX_ACK, 8'hFF), 1'b1, outcome_of(8'h00, 1'b1, 8'h00, 4'd0, 4'd0, 1'b1));
    add_row(bus_word(BS_TX_NACK, 8'h00), 1'b1, outcome_of(8'h00, 1'b1, 8'h00, 4'd0, 4'd0, 1'b1));
    add_row(bus_word(BS_ADDR_W, 8'hFF), 1'b1, outcome_of(8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 1'b1));
    add_row(bus_word(BS_OTHER_LO, 8'h00), 1'b1,
            outcome_of(8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 1'b1));
    add_row(bus_word(BS_OTHER_HI, 8'h00), 1'b1,
            outcome_of(8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 1'b1));
    begin
      in_item_t nop;
      nop = random_word();
      nop.cmd = CMD_NOP;
      add_row(nop, 1'b1, outcome_of(8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 1'b1));
    end
    add_row(read_word(4'd15, 4'd15), 1'b1, outcome_of(8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 1'b1));
    // A two-byte message with the extreme byte values, closed by the zero byte.
    add_row(bus_word(BS_DATA_RX, 8'hFF), 1'b1, outcome_of(8'h00, 1'b0, 8'h00, 4'd0, 4'd0, 1'b1));
    add_row(bus_word(BS_DATA_RX, 8'h01), 1'b0, '0);
    add_row(bus_word(BS_DATA_RX, 8'h00), 1'b1, outcome_of(8'h00, 1'b0, 8'h00, 4'd1, 4'd0, 1'b1));
    add_row(read_word(4'd1, 4'd0), 1'b1, outcome_of(8'h00, 1'b0, 8'hFF, 4'd1, 4'd0, 1'b1));
    add_row(read_word(4'd1, 4'd1), 1'b0, '0);
    add_row(read_word(4'd0, 4'd0), 1'b0, '0);
    // A partial transmit message: first and last byte only, then popped and sent.
    add_row(tx_word(4'd0, 8'hFF, 1'b0), 1'b0, '0);
    add_row(tx_word(4'd15, 8'h00, 1'b1), 1'b1, outcome_of(8'h00, 1'b0, 8'h00, 4'd1, 4'd0, 1'b0));
    add_row(bus_word(BS_ADDR_R, 8'h00), 1'b1, outcome_of(POP_MARK, 1'b1, 8'h00, 4'd1, 4'd0, 1'b1));
    add_row(bus_word(BS_TX_ACK, 8'h00), 1'b1, outcome_of(8'hFF, 1'b1, 8'h00, 4'd1, 4'd0, 1'b1));
    add_row(bus_word(BS_TX_ACK, 8'h00), 1'b0, '0);
    add_row(bus_word(BS_TX_NACK, 8'h00), 1'b0, '0);
    // After the nack the message restarts from its first byte.
    add_row(bus_word(BS_TX_ACK, 8'h00), 1'b0, '0);
    // An empty message: the zero byte alone commits.
    add_row(bus_word(BS_DATA_RX, 8'h00), 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) post_word(script[i].word, script[i].typed, script[i].want);
    directed_words = words_posted;

    // Forced corner runs: wrap the receive ring so the oldest message is dropped, overflow one
    // message, overrun the transmit queue, then read one message past its end.
    repeat (RING_DEPTH + 2) post(bus_word(BS_DATA_RX, 8'h00));
    repeat (MSG_BYTES + 4) post(bus_word(BS_DATA_RX, 8'($urandom_range(1, 255))));
    post(bus_word(BS_DATA_RX, 8'h00));
    for (int i = 0; i <= RING_DEPTH; i++) post(tx_word(4'($urandom), 8'($urandom), 1'b1));
    post(bus_word(BS_ADDR_R, 8'h00));
    repeat (MSG_BYTES + 2) post(bus_word(BS_TX_ACK, 8'($urandom)));

    paused = 1'b0;
    while (words_posted - directed_words < RANDOM_WORDS) begin
      idle_mode = ($urandom_range(0, 3) != 0);
      quiet = (words_posted - directed_words >= RANDOM_WORDS - QUIET_WORDS);
      if (!paused && words_posted - directed_words >= RANDOM_WORDS / 2) begin
        // Let the block drain completely before carrying on.
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 35)
        run_rx_message();
      else if (kind < 60)
        run_tx_message();
      else if (kind < 80)
        run_bus_read();
      else if (kind < 92)
        repeat ($urandom_range(1, 4)) post(read_word(4'($urandom), 4'($urandom)));
      else
        repeat ($urandom_range(1, 3)) post(random_word());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d effective words (%0d directed); checked %0d results.",
             words_posted, directed_words, results_checked);
    $display("Receive messages committed: %0d; transmit messages popped: %0d.",
             rx_commits, tx_pops);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d result mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
